>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold while out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/phc_pkg.sv
// Package: constants and helpers for the pixel to hex cell block
`timescale 1ns / 1ps
package phc_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int PIXEL_BITS_DEF = 16;
    localparam int SCALE_BITS     = 16;
    localparam int SCALE_W        = 17;
    localparam int CELL_W         = 17;
    localparam int QDEPTH         = 2;

    localparam logic [SCALE_W-1:0] INV_SCALE_RST = SCALE_W'(2048);

    // dy/D, 2dx/D, dx/D, 2dy/D in Q30
    localparam longint K_X_FROM_U = 64'sd691436639;
    localparam longint K_X_FROM_V = 64'sd370539778;
    localparam longint K_Y_FROM_U = 64'sd185269889;
    localparam longint K_Y_FROM_V = 64'sd1382873277;

    // Round a Q30 constant half up to Q(frac)
    function automatic longint coef_q(input longint k, input int frac);
        longint r;
        r = (k + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
        return r;
    endfunction

endpackage

>>> rtl/phc_front.sv
// Front: accept pixel words and project them onto the skewed axial basis
`timescale 1ns / 1ps
`include "assert_macros.svh"
module phc_front import phc_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int PW         = PIXEL_BITS + FRAC_BITS + 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [PIXEL_BITS-1:0] i_pixel_x,
    input  logic signed [PIXEL_BITS-1:0] i_pixel_y,
    output logic                         o_push,
    input  logic                         i_push_ready,
    output logic signed [PW-1:0]         o_proj_x,
    output logic signed [PW-1:0]         o_proj_y
);

    localparam int CW = FRAC_BITS + 2;
    localparam int MW = PIXEL_BITS + CW;

    localparam logic signed [CW-1:0] C_XU = CW'(coef_q(K_X_FROM_U, FRAC_BITS));
    localparam logic signed [CW-1:0] C_XV = CW'(coef_q(K_X_FROM_V, FRAC_BITS));
    localparam logic signed [CW-1:0] C_YU = CW'(coef_q(K_Y_FROM_U, FRAC_BITS));
    localparam logic signed [CW-1:0] C_YV = CW'(coef_q(K_Y_FROM_V, FRAC_BITS));

    logic                 r_v1, r_v2;
    logic signed [MW-1:0] r_xu, r_xv, r_yu, r_yv;
    logic signed [PW-1:0] r_px, r_py;
    logic                 w_adv;

    assign w_adv      = !(r_v2 && !i_push_ready);
    assign o_in_ready = w_adv;
    assign o_push     = r_v2 && i_push_ready;
    assign o_proj_x   = r_px;
    assign o_proj_y   = r_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xu <= C_XU * i_pixel_x;
            r_xv <= C_XV * i_pixel_y;
            r_yu <= C_YU * i_pixel_x;
            r_yv <= C_YV * i_pixel_y;
            r_px <= PW'(r_xu) - PW'(r_xv);
            r_py <= PW'(r_yv) - PW'(r_yu);
        end
    end

endmodule

>>> rtl/phc_queue.sv
// Queue: short FIFO between front and back
`timescale 1ns / 1ps
`include "assert_macros.svh"
module phc_queue import phc_pkg::*; #(
    parameter int DW = 70
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_push_ready,
    input  logic [DW-1:0] i_data,
    output logic          o_valid,
    input  logic          i_pop,
    output logic [DW-1:0] o_data
);

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int NW = $clog2(QDEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(QDEPTH - 1);
    localparam logic [NW-1:0] FULL = NW'(QDEPTH);

    logic [DW-1:0] r_mem [QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_count;

    assign o_push_ready = (r_count != FULL);
    assign o_valid      = (r_count != '0);
    assign o_data       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_q_over, i_clk, i_rst_n, r_count > FULL, "queue count above depth")
    `ASSERT_CLK(a_q_fill, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1), "queue count did not advance on push")

endmodule

>>> rtl/phc_back.sv
// Back: scale, cube-round and emit the hex cell
`timescale 1ns / 1ps
`include "assert_macros.svh"
module phc_back import phc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int PW        = 35
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [SCALE_W-1:0]        i_inv_scale,
    input  logic                      i_q_valid,
    output logic                      o_pop,
    input  logic signed [PW-1:0]      i_proj_x,
    input  logic signed [PW-1:0]      i_proj_y,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [CELL_W-1:0]  o_cell_x,
    output logic signed [CELL_W-1:0]  o_cell_y
);

    localparam int HW = PW - SCALE_BITS;
    localparam int LW = SCALE_BITS + SCALE_W;
    localparam int GW = HW + SCALE_W + 1;
    localparam int FW = GW + 1;
    localparam int ZW = FW + 1;
    localparam int SW = FRAC_BITS + 1;
    localparam logic [LW-1:0] LO_HALF = LW'(1) << (SCALE_BITS - 1);

    function automatic logic signed [ZW-1:0] rnd(input logic signed [ZW-1:0] a);
        logic signed [ZW:0] m;
        m = a[ZW-1] ? -(ZW+1)'(a) : (ZW+1)'(a);
        m = (m + ((ZW+1)'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return a[ZW-1] ? ZW'(-m) : ZW'(m);
    endfunction

    function automatic logic [SW-1:0] stray(input logic signed [ZW-1:0] r,
                                            input logic signed [ZW-1:0] a);
        logic signed [ZW:0] d;
        d = ((ZW+1)'(r) <<< FRAC_BITS) - (ZW+1)'(a);
        d = d[ZW] ? -d : d;
        return d[SW-1:0];
    endfunction

    logic [4:0]               r_vld;
    logic                     w_adv;

    logic [LW-1:0]            r_lo_x, r_lo_y;
    logic signed [GW-1:0]     r_hi_x, r_hi_y;
    logic signed [FW-1:0]     r_fx, r_fy;
    logic signed [ZW-1:0]     r_ax, r_ay, r_az, r_rx, r_ry, r_rz;
    logic [SW-1:0]            r_sx, r_sy, r_sz;
    logic signed [CELL_W-1:0] r_cx, r_cy, r_cz;
    logic signed [CELL_W-1:0] r_ox, r_oy;
    logic signed [ZW-1:0]     w_fz;

    assign w_adv       = !(r_vld[4] && !i_out_ready);
    assign o_pop       = i_q_valid && w_adv;
    assign o_out_valid = r_vld[4];
    assign o_cell_x    = r_ox;
    assign o_cell_y    = r_oy;
    assign w_fz        = -ZW'(r_fx) - ZW'(r_fy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[3:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lo_x <= i_proj_x[SCALE_BITS-1:0] * i_inv_scale;
            r_lo_y <= i_proj_y[SCALE_BITS-1:0] * i_inv_scale;
            r_hi_x <= $signed(i_proj_x[PW-1:SCALE_BITS]) * $signed({1'b0, i_inv_scale});
            r_hi_y <= $signed(i_proj_y[PW-1:SCALE_BITS]) * $signed({1'b0, i_inv_scale});

            r_fx <= FW'(r_hi_x) + FW'((r_lo_x + LO_HALF) >> SCALE_BITS);
            r_fy <= FW'(r_hi_y) + FW'((r_lo_y + LO_HALF) >> SCALE_BITS);

            r_ax <= ZW'(r_fx);
            r_ay <= ZW'(r_fy);
            r_az <= w_fz;
            r_rx <= rnd(ZW'(r_fx));
            r_ry <= rnd(ZW'(r_fy));
            r_rz <= rnd(w_fz);

            r_sx <= stray(r_rx, r_ax);
            r_sy <= stray(r_ry, r_ay);
            r_sz <= stray(r_rz, r_az);
            r_cx <= r_rx[CELL_W-1:0];
            r_cy <= r_ry[CELL_W-1:0];
            r_cz <= r_rz[CELL_W-1:0];

            if (r_sx > r_sy && r_sx > r_sz) begin
                r_ox <= -r_cy - r_cz;
                r_oy <= r_cy;
            end else if (r_sy > r_sz) begin
                r_ox <= r_cx;
                r_oy <= -r_cx - r_cz;
            end else begin
                r_ox <= r_cx;
                r_oy <= r_cy;
            end
        end
    end

    `ASSERT_CLK(a_b_flow, i_clk, i_rst_n, (r_vld[3] && w_adv) |=> r_vld[4], "back stage lost a word")

endmodule

>>> rtl/pixel_to_hex_cell_top.sv
// Top level: pixel position to isometric hex cell
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_pixel_x, i_pixel_y
//  out     | output    | o_out_valid / i_out_ready | o_cell_x, o_cell_y
//  cfg     | input     | i_cfg_wr_en (no wait)     | i_cfg_wr_data (inv_scale)
//
//  One word per cycle sustained unless the output stalls; a word passes the
//  front registers, the queue memory and the back stages. Throughput is set by
//  the four coefficient and four scale multipliers, each used once per word.
//  Synchronous active-low reset clears all valid bits; inv_scale resets to 1/32.
//  A stalled output holds the back pipeline; the 2-word queue then fills
//  and the front stops taking words.
`timescale 1ns / 1ps
module pixel_to_hex_cell_top import phc_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [SCALE_W-1:0]           i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [PIXEL_BITS-1:0] i_pixel_x,
    input  logic signed [PIXEL_BITS-1:0] i_pixel_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [CELL_W-1:0]     o_cell_x,
    output logic signed [CELL_W-1:0]     o_cell_y
);

    localparam int PW = PIXEL_BITS + FRAC_BITS + 3;

    logic [SCALE_W-1:0]   r_inv_scale;
    logic                 w_push, w_push_ready, w_q_valid, w_pop;
    logic signed [PW-1:0] w_fx, w_fy;
    logic [2*PW-1:0]      w_q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_scale <= INV_SCALE_RST;
        end else if (i_cfg_wr_en) begin
            r_inv_scale <= i_cfg_wr_data;
        end
    end

    phc_front #(
        .FRAC_BITS  (FRAC_BITS),
        .PIXEL_BITS (PIXEL_BITS),
        .PW         (PW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_proj_x     (w_fx),
        .o_proj_y     (w_fy)
    );

    phc_queue #(
        .DW (2 * PW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_data       ({w_fx, w_fy}),
        .o_valid      (w_q_valid),
        .i_pop        (w_pop),
        .o_data       (w_q_out)
    );

    phc_back #(
        .FRAC_BITS (FRAC_BITS),
        .PW        (PW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_inv_scale (r_inv_scale),
        .i_q_valid   (w_q_valid),
        .o_pop       (w_pop),
        .i_proj_x    ($signed(w_q_out[2*PW-1:PW])),
        .i_proj_y    ($signed(w_q_out[PW-1:0])),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cell_x    (o_cell_x),
        .o_cell_y    (o_cell_y)
    );

endmodule
